>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the contact controller rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every clock outside reset
`define TPCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define TPCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tpcc_pkg.sv
// ---------------------------------------------------------------------------
// tpcc_pkg
// shared types, constants and saturation helper for the contact controller
// ---------------------------------------------------------------------------
package tpcc_pkg;

    localparam int CFG_AW  = 5;
    localparam int GAIN_W  = 31;
    localparam int Q_W     = 32;
    localparam int OP_W    = 33;
    localparam int PROD_W  = 48;
    localparam int SUM_W   = 50;

    // phase codes
    localparam logic [1:0] PH_APPROACH  = 2'd0;
    localparam logic [1:0] PH_IMPEDANCE = 2'd1;
    localparam logic [1:0] PH_SLIDE     = 2'd2;

    // register indexes
    localparam logic [2:0] REG_APPROACH_KP    = 3'd0;
    localparam logic [2:0] REG_APPROACH_KI_DT = 3'd1;
    localparam logic [2:0] REG_APPROACH_KD_DT = 3'd2;
    localparam logic [2:0] REG_SLIDE_KP       = 3'd3;
    localparam logic [2:0] REG_SLIDE_KD_DT    = 3'd4;
    localparam logic [2:0] REG_STIFFNESS      = 3'd5;
    localparam logic [2:0] REG_DAMPING        = 3'd6;
    localparam logic [2:0] REG_VEL_EPSILON    = 3'd7;

    // reset values
    localparam logic [GAIN_W-1:0] RST_APPROACH_KP    = 31'd32768;
    localparam logic [GAIN_W-1:0] RST_APPROACH_KI_DT = 31'd66;
    localparam logic [GAIN_W-1:0] RST_APPROACH_KD_DT = 31'd65536;
    localparam logic [GAIN_W-1:0] RST_SLIDE_KP       = 31'd3277;
    localparam logic [GAIN_W-1:0] RST_SLIDE_KD_DT    = 31'd32768;
    localparam logic [GAIN_W-1:0] RST_STIFFNESS      = 31'd3277;
    localparam logic [GAIN_W-1:0] RST_DAMPING        = 31'd3277;
    localparam logic [GAIN_W-1:0] RST_VEL_EPSILON    = 31'd6554;

    localparam logic signed [SUM_W-1:0] SAT_HI = 50'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_LO = -50'sd2147483648;

    typedef struct packed {
        logic [GAIN_W-1:0] approach_kp;
        logic [GAIN_W-1:0] approach_ki_dt;
        logic [GAIN_W-1:0] approach_kd_dt;
        logic [GAIN_W-1:0] slide_kp;
        logic [GAIN_W-1:0] slide_kd_dt;
        logic [GAIN_W-1:0] stiffness;
        logic [GAIN_W-1:0] damping;
        logic [GAIN_W-1:0] vel_epsilon;
    } t_gains;

    // three gain/operand pairs plus the tick's phase outcome
    typedef struct packed {
        logic [GAIN_W-1:0]      gain_a;
        logic signed [OP_W-1:0] op_a;
        logic [GAIN_W-1:0]      gain_b;
        logic signed [OP_W-1:0] op_b;
        logic [GAIN_W-1:0]      gain_c;
        logic signed [OP_W-1:0] op_c;
        logic [1:0]             phase;
        logic                   changed;
    } t_mul_ops;

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI) begin
            return 32'sh7fffffff;
        end else if (v < SAT_LO) begin
            return 32'sh80000000;
        end else begin
            return v[Q_W-1:0];
        end
    endfunction

endpackage

>>> rtl/tpcc_cfg.sv
// ---------------------------------------------------------------------------
// tpcc_cfg
// apb register file holding the eight controller gains
// ---------------------------------------------------------------------------
module tpcc_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpcc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output tpcc_pkg::t_gains           o_gains
);
    import tpcc_pkg::*;

    t_gains          r_gains;
    logic            w_wr;
    logic [2:0]      w_idx;
    logic [GAIN_W-1:0] w_rd;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.approach_kp    <= RST_APPROACH_KP;
            r_gains.approach_ki_dt <= RST_APPROACH_KI_DT;
            r_gains.approach_kd_dt <= RST_APPROACH_KD_DT;
            r_gains.slide_kp       <= RST_SLIDE_KP;
            r_gains.slide_kd_dt    <= RST_SLIDE_KD_DT;
            r_gains.stiffness      <= RST_STIFFNESS;
            r_gains.damping        <= RST_DAMPING;
            r_gains.vel_epsilon    <= RST_VEL_EPSILON;
        end else if (w_wr) begin
            case (w_idx)
                REG_APPROACH_KP:    r_gains.approach_kp    <= pwdata[GAIN_W-1:0];
                REG_APPROACH_KI_DT: r_gains.approach_ki_dt <= pwdata[GAIN_W-1:0];
                REG_APPROACH_KD_DT: r_gains.approach_kd_dt <= pwdata[GAIN_W-1:0];
                REG_SLIDE_KP:       r_gains.slide_kp       <= pwdata[GAIN_W-1:0];
                REG_SLIDE_KD_DT:    r_gains.slide_kd_dt    <= pwdata[GAIN_W-1:0];
                REG_STIFFNESS:      r_gains.stiffness      <= pwdata[GAIN_W-1:0];
                REG_DAMPING:        r_gains.damping        <= pwdata[GAIN_W-1:0];
                default:            r_gains.vel_epsilon    <= pwdata[GAIN_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_APPROACH_KP:    w_rd = r_gains.approach_kp;
            REG_APPROACH_KI_DT: w_rd = r_gains.approach_ki_dt;
            REG_APPROACH_KD_DT: w_rd = r_gains.approach_kd_dt;
            REG_SLIDE_KP:       w_rd = r_gains.slide_kp;
            REG_SLIDE_KD_DT:    w_rd = r_gains.slide_kd_dt;
            REG_STIFFNESS:      w_rd = r_gains.stiffness;
            REG_DAMPING:        w_rd = r_gains.damping;
            default:            w_rd = r_gains.vel_epsilon;
        endcase
    end

    assign prdata  = {1'b0, w_rd};
    assign pready  = 1'b1;
    assign o_gains = r_gains;

endmodule

>>> rtl/tpcc_phase.sv
// ---------------------------------------------------------------------------
// tpcc_phase
// phase supervisor: error terms, integral, phase state and multiplier operands
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpcc_phase (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic signed [tpcc_pkg::Q_W-1:0] i_pos,
    input  logic signed [tpcc_pkg::Q_W-1:0] i_vel,
    input  logic signed [tpcc_pkg::Q_W-1:0] i_atgt,
    input  logic signed [tpcc_pkg::Q_W-1:0] i_ctgt,
    input  tpcc_pkg::t_gains              i_gains,
    output tpcc_pkg::t_mul_ops            o_ops
);
    import tpcc_pkg::*;

    logic [1:0]             r_phase;
    logic signed [Q_W-1:0]  r_integral;
    logic signed [Q_W-1:0]  r_prev_err;
    logic signed [Q_W-1:0]  r_held_err;

    logic [1:0]             n_phase;
    logic signed [Q_W-1:0]  n_integral;
    logic signed [Q_W-1:0]  n_prev_err;
    logic signed [Q_W-1:0]  n_held_err;

    logic signed [OP_W-1:0] w_pos;
    logic signed [OP_W-1:0] w_vel;
    logic signed [OP_W-1:0] w_neg_vel;
    logic signed [OP_W-1:0] w_mag_vel;
    logic signed [OP_W-1:0] w_raw_a;
    logic signed [OP_W-1:0] w_raw_c;
    logic signed [Q_W-1:0]  w_err;
    logic signed [OP_W-1:0] w_err_diff;
    logic signed [OP_W-1:0] w_integ_sum;
    logic signed [Q_W-1:0]  w_integ_new;
    logic                   w_slow;

    assign w_pos     = {i_pos[Q_W-1], i_pos};
    assign w_vel     = {i_vel[Q_W-1], i_vel};
    assign w_neg_vel = -w_vel;
    assign w_mag_vel = i_vel[Q_W-1] ? w_neg_vel : w_vel;
    assign w_slow    = w_mag_vel < $signed({2'b00, i_gains.vel_epsilon});

    assign w_raw_a = $signed({i_atgt[Q_W-1], i_atgt}) - w_pos;
    assign w_raw_c = $signed({i_ctgt[Q_W-1], i_ctgt}) - w_pos;
    assign w_err   = (r_phase == PH_APPROACH) ? sat32(SUM_W'(w_raw_a)) : sat32(SUM_W'(w_raw_c));

    // derivative uses the exact 33-bit difference
    assign w_err_diff  = $signed({w_err[Q_W-1], w_err}) - $signed({r_prev_err[Q_W-1], r_prev_err});
    assign w_integ_sum = $signed({w_err[Q_W-1], w_err})
                       + $signed({r_integral[Q_W-1], r_integral});
    assign w_integ_new = sat32(SUM_W'(w_integ_sum));

    always_comb begin
        n_phase       = r_phase;
        n_integral    = r_integral;
        n_prev_err    = r_prev_err;
        n_held_err    = r_held_err;
        o_ops.changed = 1'b0;
        case (r_phase)
            PH_APPROACH: begin
                n_integral   = w_integ_new;
                n_prev_err   = w_err;
                n_held_err   = w_err;
                o_ops.gain_a = i_gains.approach_kp;
                o_ops.op_a   = {w_err[Q_W-1], w_err};
                o_ops.gain_b = i_gains.approach_ki_dt;
                o_ops.op_b   = {w_integ_new[Q_W-1], w_integ_new};
                o_ops.gain_c = i_gains.approach_kd_dt;
                o_ops.op_c   = w_err_diff;
                if (i_pos < i_atgt) begin
                    n_phase       = PH_IMPEDANCE;
                    o_ops.changed = 1'b1;
                end
            end
            PH_IMPEDANCE: begin
                // held error and integral stay frozen here
                o_ops.gain_a = i_gains.stiffness;
                o_ops.op_a   = {r_held_err[Q_W-1], r_held_err};
                o_ops.gain_b = i_gains.damping;
                o_ops.op_b   = w_neg_vel;
                o_ops.gain_c = '0;
                o_ops.op_c   = '0;
                if (w_slow) begin
                    n_phase       = PH_SLIDE;
                    o_ops.changed = 1'b1;
                end
            end
            default: begin
                // slide, also taken for the unused code
                n_prev_err   = w_err;
                n_held_err   = w_err;
                o_ops.gain_a = i_gains.slide_kp;
                o_ops.op_a   = {w_err[Q_W-1], w_err};
                o_ops.gain_b = '0;
                o_ops.op_b   = '0;
                o_ops.gain_c = i_gains.slide_kd_dt;
                o_ops.op_c   = w_err_diff;
            end
        endcase
        o_ops.phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_APPROACH;
            r_integral <= '0;
            r_prev_err <= '0;
            r_held_err <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_integral <= n_integral;
            r_prev_err <= n_prev_err;
            r_held_err <= n_held_err;
        end
    end

    `TPCC_ASSERT_NXT(a_slide_sticks, r_phase == PH_SLIDE, r_phase == PH_SLIDE, "left slide phase")
    `TPCC_ASSERT_NXT(a_state_idle, !i_fire, $stable(r_phase) && $stable(r_prev_err), "state moved without a transaction")
    `TPCC_ASSERT_NXT(a_integ_approach, i_fire && r_phase != PH_APPROACH, $stable(r_integral), "integral changed outside approach")

endmodule

>>> rtl/tpcc_mult.sv
// ---------------------------------------------------------------------------
// tpcc_mult
// three gain-by-value multipliers with registered q32.16 products
// ---------------------------------------------------------------------------
module tpcc_mult (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  tpcc_pkg::t_mul_ops                 i_ops,
    output logic signed [tpcc_pkg::PROD_W-1:0] o_prod_a,
    output logic signed [tpcc_pkg::PROD_W-1:0] o_prod_b,
    output logic signed [tpcc_pkg::PROD_W-1:0] o_prod_c,
    output logic [1:0]                         o_phase,
    output logic                               o_changed
);
    import tpcc_pkg::*;

    logic signed [64:0]       w_full_a;
    logic signed [64:0]       w_full_b;
    logic signed [64:0]       w_full_c;
    logic signed [PROD_W-1:0] r_prod_a;
    logic signed [PROD_W-1:0] r_prod_b;
    logic signed [PROD_W-1:0] r_prod_c;
    logic [1:0]               r_phase;
    logic                     r_changed;

    assign w_full_a = $signed({1'b0, i_ops.gain_a}) * $signed(i_ops.op_a);
    assign w_full_b = $signed({1'b0, i_ops.gain_b}) * $signed(i_ops.op_b);
    assign w_full_c = $signed({1'b0, i_ops.gain_c}) * $signed(i_ops.op_c);

    // dropping the low 16 bits floors toward minus infinity
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_a  <= w_full_a[63:16];
            r_prod_b  <= w_full_b[63:16];
            r_prod_c  <= w_full_c[63:16];
            r_phase   <= i_ops.phase;
            r_changed <= i_ops.changed;
        end
    end

    assign o_prod_a  = r_prod_a;
    assign o_prod_b  = r_prod_b;
    assign o_prod_c  = r_prod_c;
    assign o_phase   = r_phase;
    assign o_changed = r_changed;

endmodule

>>> rtl/three_phase_contact_controller.sv
// ---------------------------------------------------------------------------
// three_phase_contact_controller
// approach pid, impedance and slide pd supervisor in q16.16 fixed point
// ---------------------------------------------------------------------------
// channel   direction  handshake                   payload
// in        sink       i_in_valid / o_in_stall     pos, vel, approach and contact targets
// out       source     o_out_valid / i_out_stall   drive_cmd, phase, phase_changed
// cfg       apb slave  psel / penable / pready     eight 31-bit gains at 4*index
//
// one transaction per cycle unless i_out_stall holds the pipeline; a result passes through the
// input register, phase/operand stage into the product register, sum and
// saturate into the result register; the state loop closes in the phase stage
// synchronous active-low reset clears phase, integral, errors, presets gains
// a stall only holds stages that are full, empty stages keep filling
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module three_phase_contact_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [31:0]               i_measured_pos,
    input  logic signed [31:0]               i_measured_vel,
    input  logic signed [31:0]               i_approach_target,
    input  logic signed [31:0]               i_contact_target,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [31:0]               o_drive_cmd,
    output logic [1:0]                       o_phase,
    output logic                             o_phase_changed,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tpcc_pkg::CFG_AW-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import tpcc_pkg::*;

    t_gains                w_gains;
    t_mul_ops              w_ops;

    logic                  r_in_valid;
    logic signed [Q_W-1:0] r_pos;
    logic signed [Q_W-1:0] r_vel;
    logic signed [Q_W-1:0] r_atgt;
    logic signed [Q_W-1:0] r_ctgt;

    logic                  r_mul_valid;
    logic signed [PROD_W-1:0] w_prod_a;
    logic signed [PROD_W-1:0] w_prod_b;
    logic signed [PROD_W-1:0] w_prod_c;
    logic [1:0]            w_mul_phase;
    logic                  w_mul_changed;

    logic                  r_out_valid;
    logic signed [Q_W-1:0] r_cmd;
    logic [1:0]            r_phase;
    logic                  r_changed;

    logic                  w_s1_ready;
    logic                  w_s2_ready;
    logic                  w_s3_ready;
    logic                  w_s1_fire;
    logic signed [SUM_W-1:0] w_sum;

    assign w_s3_ready = !r_out_valid || !i_out_stall;
    assign w_s2_ready = !r_mul_valid || w_s3_ready;
    assign w_s1_ready = !r_in_valid || w_s2_ready;
    assign w_s1_fire  = r_in_valid && w_s2_ready;
    assign o_in_stall = !w_s1_ready;

    tpcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (w_gains)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_s2_ready) begin
                r_mul_valid <= r_in_valid;
            end
            if (w_s3_ready) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_pos  <= i_measured_pos;
            r_vel  <= i_measured_vel;
            r_atgt <= i_approach_target;
            r_ctgt <= i_contact_target;
        end
    end

    tpcc_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_s1_fire),
        .i_pos   (r_pos),
        .i_vel   (r_vel),
        .i_atgt  (r_atgt),
        .i_ctgt  (r_ctgt),
        .i_gains (w_gains),
        .o_ops   (w_ops)
    );

    tpcc_mult u_mult (
        .i_clk     (i_clk),
        .i_en      (w_s1_fire),
        .i_ops     (w_ops),
        .o_prod_a  (w_prod_a),
        .o_prod_b  (w_prod_b),
        .o_prod_c  (w_prod_c),
        .o_phase   (w_mul_phase),
        .o_changed (w_mul_changed)
    );

    assign w_sum = SUM_W'(w_prod_a) + SUM_W'(w_prod_b) + SUM_W'(w_prod_c);

    always_ff @(posedge i_clk) begin
        if (w_s3_ready) begin
            r_cmd     <= sat32(w_sum);
            r_phase   <= w_mul_phase;
            r_changed <= w_mul_changed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_cmd     = r_cmd;
    assign o_phase         = r_phase;
    assign o_phase_changed = r_changed;

    `TPCC_ASSERT_IMP(a_empty_takes, !r_out_valid, !o_in_stall, "stalled with an empty result register")
    `TPCC_ASSERT_NXT(a_mul_kept, r_mul_valid && !w_s3_ready, r_mul_valid, "product stage dropped a transaction")

endmodule
